// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk_sig, rstn_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk_sig, rstn_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr)

`endif

`endif

// File: hdl/blte_pkg.sv
// ----------------------------------------------------------------------------
// blte_pkg
// operation and status codes of the bounded list table engine
// ----------------------------------------------------------------------------
package blte_pkg;

	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 4;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int LEN_W    = 5;

	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOB      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

// File: hdl/bounded_list_table_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_list_table_engine_top
// ordered list of up to CAPACITY words with append, read, write, find, remove
// ----------------------------------------------------------------------------
// Input beats arrive on the s_ group: s_tuser carries the operation kind,
// s_tdata the index and value. Each input beat gives exactly one result beat
// on the m_ group: status, read data, position and the new list length.
// The list lives in a memory with one write port and one registered read
// port, walked by a small sequencer with one shared comparator.
// Each beat passes S_EXEC and then S_RESP. Unknown kinds, append, write and
// out-of-bounds accesses go straight between them; a read adds S_RD_WAIT; a
// find adds S_SCAN_RD and S_SCAN_CMP per entry examined; a remove does as
// find, plus S_SHIFT_RD and S_SHIFT_WR per entry moved down after the match.
// Each entry costs a memory read step and a compare or write step. s_tready
// is high only while the sequencer is idle.
// The result sits in an output register, so a new beat is taken while a
// finished result still waits; a stalled receiver holds m_tvalid and m_tdata
// and the sequencer waits to load the next result. Reset empties the list;
// stored words are left as they were and are never read before written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_list_table_engine_top
	import blte_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // index[3:0], value[35:4], zero pad
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[1:0], read_data[33:2], position[37:34],
	                               // length[42:38], zero pad
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           ptr_q;
	logic [KIND_W-1:0]       kind_q;
	logic [INDEX_W-1:0]      idx_q;
	logic [WORD_WIDTH-1:0]   word_q;
	logic [STATUS_W-1:0]     res_st_q;
	logic [VALUE_W-1:0]      res_rd_q;
	logic [AW-1:0]           res_pos_q;

	logic                    out_vld_q;
	logic [STATUS_W-1:0]     out_st_q;
	logic [VALUE_W-1:0]      out_rd_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [LEN_W-1:0]        out_len_q;

	logic [WORD_WIDTH-1:0]   mem [CAPACITY];
	logic [WORD_WIDTH-1:0]   rdata_q;
	logic                    mem_we;
	logic [AW-1:0]           mem_wa;
	logic [WORD_WIDTH-1:0]   mem_wd;
	logic [AW-1:0]           mem_ra;

	logic                    idx_oob;
	logic                    list_full;
	logic [CW-1:0]           ptr_p1;
	logic [CW-1:0]           ptr_p2;
	logic                    hit;
	logic                    out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_len_q, out_pos_q, out_rd_q, out_st_q};

	assign idx_oob   = (XW'(idx_q) >= XW'(count_q));
	assign list_full = (count_q == CW'(CAPACITY));
	assign ptr_p1    = CW'(ptr_q) + CW'(1);
	assign ptr_p2    = CW'(ptr_q) + CW'(2);
	assign hit       = (rdata_q == word_q);
	assign out_free  = !out_vld_q || m_tready;

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = word_q;
		mem_ra = ptr_q;
		unique case (state_q)
			S_EXEC: begin
				mem_ra = AW'(idx_q);
				if (kind_q == KIND_APPEND && !list_full) begin
					mem_we = 1'b1;
					mem_wa = AW'(count_q);
				end else if (kind_q == KIND_WRITE && !idx_oob) begin
					mem_we = 1'b1;
					mem_wa = AW'(idx_q);
				end
			end
			S_SHIFT_RD: begin
				mem_ra = AW'(ptr_p1);
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
				mem_wd = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready && state_q != S_RESP) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q    <= s_tuser;
						idx_q     <= s_tdata[3:0];
						word_q    <= WORD_WIDTH'(s_tdata[35:4]);
						res_st_q  <= ST_OK;
						res_rd_q  <= '0;
						res_pos_q <= '0;
						ptr_q     <= '0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (kind_q)
						KIND_APPEND: begin
							if (list_full) begin
								res_st_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_RESP;
						end
						KIND_READ: begin
							if (idx_oob) begin
								res_st_q <= ST_OOB;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_RD_WAIT;
							end
						end
						KIND_WRITE: begin
							if (idx_oob) begin
								res_st_q <= ST_OOB;
							end
							state_q <= S_RESP;
						end
						KIND_FIND, KIND_REMOVE: begin
							if (count_q == '0) begin
								res_st_q <= ST_NOTFOUND;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_RD_WAIT: begin
					res_rd_q <= VALUE_W'(rdata_q);
					state_q  <= S_RESP;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (hit) begin
						res_pos_q <= ptr_q;
						if (kind_q != KIND_REMOVE) begin
							state_q <= S_RESP;
						end else if (ptr_p1 < count_q) begin
							state_q <= S_SHIFT_RD;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= S_RESP;
						end
					end else if (ptr_p1 >= count_q) begin
						res_st_q <= ST_NOTFOUND;
						state_q  <= S_RESP;
					end else begin
						ptr_q   <= AW'(ptr_p1);
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (ptr_p2 >= count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end else begin
						ptr_q   <= AW'(ptr_p1);
						state_q <= S_SHIFT_RD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						out_st_q  <= res_st_q;
						out_rd_q  <= res_rd_q;
						out_pos_q <= POS_W'(res_pos_q);
						out_len_q <= LEN_W'(count_q);
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(CAPACITY))

	`ASSERT_PROP(a_one_beat_at_a_time, clk, arst_n,
		(s_tvalid && s_tready) |=> !s_tready)

	`ASSERT_PROP(a_count_step, clk, arst_n,
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))

	`ASSERT_PROP(a_load_only_when_free, clk, arst_n,
		(out_vld_q && !m_tready) |=> (out_vld_q && $stable(out_st_q) && $stable(out_len_q)))

endmodule
